>>> rtl/core/tama_pkg.sv
// Shared constants and types for the three-axis moving-average tare block.
`timescale 1ns / 1ps

package tama_pkg;

    localparam int WINDOW_DEF      = 5;
    localparam int SAMPLE_BITS_DEF = 20;
    localparam int OUT_W           = 21;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef logic signed [OUT_W-1:0] out_t;

endpackage

>>> rtl/core/tama_sample_ram.sv
// Window sample memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module tama_sample_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 5,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/tama_div.sv
// Radix-2 restoring divider lane: signed sum by small unsigned count, truncating toward zero.
`timescale 1ns / 1ps

module tama_div #(
    parameter int SUM_W = 24,
    parameter int CNT_W = 3,
    parameter int Q_W   = 20
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    busy,
    output logic signed [Q_W-1:0]   quotient
);

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic              busy_reg,  busy_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [SUM_W-1:0]  mag_reg,   mag_next;
    logic [CNT_W-1:0]  rem_reg,   rem_next;
    logic [CNT_W-1:0]  div_reg,   div_next;
    logic              neg_reg,   neg_next;

    logic [CNT_W:0]    rem_shift;
    logic              ge;
    logic [SUM_W-1:0]  q_signed;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        rem_shift = {rem_reg, mag_reg[SUM_W-1]};
        ge        = (rem_shift >= {1'b0, div_reg});
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            mag_next  = dividend[SUM_W-1] ? (-dividend) : dividend;
            rem_next  = '0;
            div_next  = divisor;
            neg_next  = dividend[SUM_W-1];
        end else if (busy_reg) begin
            rem_next = ge ? CNT_W'(rem_shift - {1'b0, div_reg}) : rem_shift[CNT_W-1:0];
            mag_next = {mag_reg[SUM_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        step_reg <= step_next;
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        neg_reg  <= neg_next;
    end

    assign q_signed = neg_reg ? (-mag_reg) : mag_reg;
    assign quotient = q_signed[Q_W-1:0];
    assign busy     = busy_reg;

endmodule

>>> rtl/core/three_axis_moving_average_tare.sv
// Top level: three-axis moving average over a sample memory, tare offset, saturated output.
//
//  channel  | direction | ports                        | content
//  s_       | in        | s_tvalid s_tready s_tdata    | force_x, force_y, force_z
//  m_       | out       | m_tvalid m_tready m_tdata    | feedback_x, feedback_y, feedback_z
//
//  One item at a time: the oldest sample is read at the accept edge, the CALC state updates
//  the sums and writes the sample back, the DIV state starts the divider lanes, which take
//  one quotient bit per cycle over the sum width (24 bits at the defaults), and sees them
//  finish, and the DONE state loads the result into the output register.
//  Reset (aresetn low, synchronous) clears count, ring slot, running sums and tare flag.
//  The next item is taken while a result waits in the output register; a stalled output
//  only holds the block once the following result is ready.
`timescale 1ns / 1ps

module three_axis_moving_average_tare #(
    parameter int WINDOW      = tama_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = tama_pkg::SAMPLE_BITS_DEF,
    parameter int IN_TDATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // force_x, force_y, force_z (SAMPLE_BITS each), zero padding
    input  logic [IN_TDATA_W-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // feedback_x, feedback_y, feedback_z (21 bits each), zero padding
    output logic [63:0]           m_tdata
);

    localparam int SB     = SAMPLE_BITS;
    localparam int OW     = tama_pkg::OUT_W;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = SB + $clog2(WINDOW) + 1;
    localparam int DIFF_W = SB + 1;
    localparam int EXT_W  = (DIFF_W > OW) ? DIFF_W : OW;
    localparam logic signed [EXT_W-1:0] OUT_MAX = EXT_W'((64'sd1 <<< (OW - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] OUT_MIN = -(EXT_W'(64'sd1 <<< (OW - 1)));

    tama_pkg::state_t state_reg, state_next;

    logic [3*SB-1:0]        sample_reg, sample_next;
    logic [SLOT_W-1:0]      slot_reg,   slot_next;
    logic [CNT_W-1:0]       count_reg,  count_next;
    logic signed [SUM_W-1:0] sum_reg   [3];
    logic signed [SUM_W-1:0] sum_next  [3];
    logic signed [SB-1:0]   tare_reg   [3];
    logic signed [SB-1:0]   tare_next  [3];
    logic                   tare_taken_reg, tare_taken_next;
    logic                   m_tvalid_reg,   m_tvalid_next;
    logic [63:0]            m_tdata_reg,    m_tdata_next;

    // divider start in the cycle after the sum update, from the registered sums
    logic                   start_pending_reg;

    logic [3*SB-1:0]        rd_data;
    logic                   wr_en;
    logic                   div_start;
    logic                   busy [3];
    logic signed [SB-1:0]   avg  [3];
    logic signed [SB-1:0]   tare_eff [3];
    tama_pkg::out_t         res  [3];
    logic                   s_accept;
    logic                   out_free;
    logic                   full;

    function automatic tama_pkg::out_t sat_out(input logic signed [DIFF_W-1:0] d);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(d);
        if (e > OUT_MAX) begin
            return OW'(OUT_MAX);
        end else if (e < OUT_MIN) begin
            return OW'(OUT_MIN);
        end
        return OW'(e);
    endfunction

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign full     = (count_reg == CNT_W'(WINDOW));

    tama_sample_ram #(
        .WIDTH (3 * SB),
        .DEPTH (WINDOW),
        .ADDR_W(SLOT_W)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(slot_reg),
        .wr_data(sample_reg),
        .rd_addr(slot_reg),
        .rd_data(rd_data)
    );

    for (genvar a = 0; a < 3; a++) begin : g_lane
        tama_div #(
            .SUM_W(SUM_W),
            .CNT_W(CNT_W),
            .Q_W  (SB)
        ) u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (div_start),
            .dividend(sum_reg[a]),
            .divisor (count_reg),
            .busy    (busy[a]),
            .quotient(avg[a])
        );
        assign tare_eff[a] = tare_taken_reg ? tare_reg[a] : avg[a];
    end

    assign res[0] = sat_out(DIFF_W'(tare_eff[0]) - DIFF_W'(avg[0]));
    assign res[1] = sat_out(DIFF_W'(avg[1]) - DIFF_W'(tare_eff[1]));
    assign res[2] = sat_out(DIFF_W'(tare_eff[2]) - DIFF_W'(avg[2]));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tama_pkg::ST_IDLE: if (s_tvalid) state_next = tama_pkg::ST_CALC;
            tama_pkg::ST_CALC: state_next = tama_pkg::ST_DIV;
            tama_pkg::ST_DIV: begin
                if (!start_pending_reg && !(busy[0] || busy[1] || busy[2])) begin
                    state_next = tama_pkg::ST_DONE;
                end
            end
            tama_pkg::ST_DONE: if (out_free) state_next = tama_pkg::ST_IDLE;
            default:           state_next = tama_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_tready        = 1'b0;
        wr_en           = 1'b0;
        div_start       = 1'b0;
        sample_next     = sample_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        tare_next       = tare_reg;
        tare_taken_next = tare_taken_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        case (state_reg)
            tama_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    sample_next = s_tdata[3*SB-1:0];
                end
            end
            tama_pkg::ST_CALC: begin
                wr_en = 1'b1;
                for (int a = 0; a < 3; a++) begin
                    sum_next[a] = sum_reg[a] + SUM_W'($signed(sample_reg[a*SB +: SB]))
                                  - (full ? SUM_W'($signed(rd_data[a*SB +: SB])) : '0);
                end
                slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                count_next = full ? count_reg : count_reg + 1'b1;
            end
            tama_pkg::ST_DIV: begin
                div_start = start_pending_reg;
            end
            tama_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = {1'b0, res[2], res[1], res[0]};
                    tare_next       = tare_eff;
                    tare_taken_next = 1'b1;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= tama_pkg::ST_IDLE;
            slot_reg          <= '0;
            count_reg         <= '0;
            tare_taken_reg    <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            start_pending_reg <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                sum_reg[a] <= '0;
            end
        end else begin
            state_reg         <= state_next;
            slot_reg          <= slot_next;
            count_reg         <= count_next;
            tare_taken_reg    <= tare_taken_next;
            m_tvalid_reg      <= m_tvalid_next;
            start_pending_reg <= (state_reg == tama_pkg::ST_CALC);
            sum_reg           <= sum_next;
        end
        sample_reg  <= sample_next;
        tare_reg    <= tare_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> tb/tare_average_checker.sv
// Checker: predicts tared moving-average feedback per force item and compares results.
`timescale 1ns / 1ps

module tare_average_checker #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    localparam int OUT_W = tama_pkg::OUT_W;

    typedef struct {
        tama_pkg::out_t x;
        tama_pkg::out_t y;
        tama_pkg::out_t z;
    } feedback_t;

    localparam longint FB_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint FB_MIN = -(longint'(1) <<< (OUT_W - 1));

    logic signed [SAMPLE_BITS-1:0] history [3][WINDOW];
    logic signed [SAMPLE_BITS-1:0] tare [3];
    bit                            tare_set;
    int                            held;
    int                            slot;
    feedback_t                     feedback_due [$];

    function automatic tama_pkg::out_t clamp_feedback(input longint v);
        if (v > FB_MAX) begin
            return tama_pkg::out_t'(FB_MAX);
        end
        if (v < FB_MIN) begin
            return tama_pkg::out_t'(FB_MIN);
        end
        return tama_pkg::out_t'(v);
    endfunction

    function automatic feedback_t predict_feedback(input logic [63:0] item);
        longint    sum;
        longint    avg [3];
        feedback_t fb;
        for (int a = 0; a < 3; a++) begin
            history[a][slot] = item[a*SAMPLE_BITS +: SAMPLE_BITS];
        end
        slot = (slot + 1) % WINDOW;
        if (held < WINDOW) begin
            held++;
        end
        for (int a = 0; a < 3; a++) begin
            sum = 0;
            for (int i = 0; i < WINDOW; i++) begin
                sum += longint'(history[a][i]);
            end
            avg[a] = sum / longint'(held);
        end
        if (!tare_set) begin
            for (int a = 0; a < 3; a++) begin
                tare[a] = avg[a][SAMPLE_BITS-1:0];
            end
            tare_set = 1'b1;
        end
        fb.x = clamp_feedback(longint'(tare[0]) - avg[0]);
        fb.y = clamp_feedback(avg[1] - longint'(tare[1]));
        fb.z = clamp_feedback(longint'(tare[2]) - avg[2]);
        return fb;
    endfunction

    always @(posedge aclk) begin
        feedback_t      exp_fb;
        tama_pkg::out_t act_x;
        tama_pkg::out_t act_y;
        tama_pkg::out_t act_z;
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                tare[a] = '0;
                for (int i = 0; i < WINDOW; i++) begin
                    history[a][i] = '0;
                end
            end
            tare_set = 1'b0;
            held     = 0;
            slot     = 0;
            feedback_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                act_x = m_tdata[0*OUT_W +: OUT_W];
                act_y = m_tdata[1*OUT_W +: OUT_W];
                act_z = m_tdata[2*OUT_W +: OUT_W];
                if (feedback_due.size() == 0) begin
                    $error("unexpected result item: x %0d y %0d z %0d", act_x, act_y, act_z);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_fb = feedback_due.pop_front();
                    if (act_x !== exp_fb.x || act_y !== exp_fb.y || act_z !== exp_fb.z) begin
                        fail_count <= fail_count + 1;
                    end
                    if (act_x !== exp_fb.x) begin
                        $error("feedback_x: expected %0d, got %0d", exp_fb.x, act_x);
                    end
                    if (act_y !== exp_fb.y) begin
                        $error("feedback_y: expected %0d, got %0d", exp_fb.y, act_y);
                    end
                    if (act_z !== exp_fb.z) begin
                        $error("feedback_z: expected %0d, got %0d", exp_fb.z, act_z);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                feedback_due.insert(feedback_due.size(), predict_feedback(s_tdata));
            end
        end
        pending <= feedback_due.size();
    end

endmodule

>>> tb/tb.sv
// Testbench top: force item stimulus, output stalls, timeout and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS = 1000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    int          fail_count;
    int          pending;
    int          stall_mode = 0;
    int          stall_left = 0;

    three_axis_moving_average_tare dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tare_average_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("[three_axis_moving_average_tare] ERROR");
        $finish;
    end

    // output stall pattern: free-running, half, sparse, or fully stalled stretches
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(5, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 1) == 1);
            end
            2: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_tready <= 1'b0;
            end
        endcase
    end

    task automatic send_force(input logic [19:0] fx, input logic [19:0] fy,
                              input logic [19:0] fz);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, fz, fy, fx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [19:0] pick_force();
        logic [19:0] v;
        case ($urandom_range(0, 4))
            0, 1: begin
                v = 20'($urandom);
            end
            2: begin
                v = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
            end
            3: begin
                v = 20'($urandom_range(0, 64));
                v = v - 20'd32;
            end
            default: begin
                v = 20'($urandom_range(0, 4095));
                if ($urandom_range(0, 1)) begin
                    v = ~v;
                end
            end
        endcase
        return v;
    endfunction

    initial begin
        int sent;
        int burst;
        int gap;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // tare taken at the extremes, then drive the averages to the far extremes
        send_force(20'h80000, 20'h7FFFF, 20'h80000);
        repeat (6) send_force(20'h7FFFF, 20'h80000, 20'h7FFFF);
        // truncation toward zero on odd sums of both signs
        send_force(20'h00000, 20'h00000, 20'h00000);
        send_force(20'hFFFFF, 20'h00001, 20'hFFFFF);
        send_force(20'h00001, 20'hFFFFF, 20'h00003);
        send_force(20'hFFFFD, 20'h00007, 20'hFFFFE);
        send_force(20'h55555, 20'hAAAAA, 20'h0F0F0);
        send_force(20'hAAAAA, 20'h55555, 20'hF0F0F);
        send_force(20'h7FFFF, 20'h7FFFF, 20'h80000);
        send_force(20'h80000, 20'h80000, 20'h7FFFF);
        send_force(20'h00000, 20'hFFFFF, 20'h00001);
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
                send_force(pick_force(), pick_force(), pick_force());
                sent++;
            end
            if ($urandom_range(0, 39) == 0) begin
                drain_results();
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30)
                                                  : $urandom_range(0, 3);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end

        drain_results();
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[three_axis_moving_average_tare] OK");
        end else begin
            $display("[three_axis_moving_average_tare] ERROR");
        end
        $finish;
    end

endmodule
